/* rtl/core/oef_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oef_pkg
// Shared types and constants of the one-euro position filter: fixed-point
// constants, register indexes, sequencer states and lane control structs.
// ----------------------------------------------------------------------------
package oef_pkg;

  localparam int AXES      = 3;
  localparam int FRAC_BITS = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_CUTOFF   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_CUTOFF = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT   = 8'd3;

  localparam logic [15:0] MIN_CUTOFF_RST   = 16'd77;
  localparam logic [15:0] SPEED_GAIN_RST   = 16'd51;
  localparam logic [15:0] DERIV_CUTOFF_RST = 16'd256;
  localparam logic [23:0] JUMP_LIMIT_RST   = 24'd131072;

  // 256e6 / (2*pi), and the same shifted into the alpha fraction
  localparam logic [56:0] ALPHA_C     = 57'd40743665;
  localparam logic [41:0] ALPHA_NUM   = 42'd40743665 << 16;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam int          ALPHA_STEPS = 17;

  localparam int          RATE_STEPS = 33;
  localparam logic [19:0] US_PER_S   = 20'd1000000;

  localparam logic [31:0] DT_MIN_US     = 32'd100;
  localparam logic [31:0] DT_DEFAULT_US = 32'd16667;
  localparam logic [48:0] CUTOFF_MAX    = 49'd16777215;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIST,
    S_DECIDE,
    S_RMUL,
    S_DSTART,
    S_DWAIT,
    S_RSAT,
    S_BRP,
    S_BRA,
    S_CMUL,
    S_CSUM,
    S_XMUL,
    S_ASTART,
    S_AWAIT,
    S_BPP,
    S_COMMIT,
    S_PRIME,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic jdist;
    logic prime;
    logic rmul;
    logic dstart;
    logic rsat;
    logic brp;
    logic bra;
    logic cmul;
    logic csum;
    logic xmul;
    logic astart;
    logic bpp;
    logic commit;
  } lane_ctl_t;

  typedef struct packed {
    logic        over;
    logic [47:0] sq;
    logic        busy;
  } lane_stat_t;

endpackage

/* rtl/core/oef_alpha_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oef_alpha_div
// Smoothing factor unit: alpha = 2^16 - ceil(C*2^16 / (x + C)), one
// restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
module oef_alpha_div import oef_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [55:0] x,
  output logic        busy,
  output logic [16:0] alpha
);

  logic [41:0] rem;
  logic [72:0] dsh;
  logic [16:0] q;
  logic [4:0]  cnt;
  logic        ge;
  logic [16:0] comp;

  assign ge    = {31'b0, rem} >= dsh;
  assign comp  = q + {16'b0, rem != 42'd0};
  assign alpha = ALPHA_ONE - comp;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(ALPHA_STEPS);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= ALPHA_NUM;
      dsh <= {(ALPHA_C + {1'b0, x}), 16'b0};
      q   <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh[41:0];
      end
      q   <= {q[15:0], ge};
      dsh <= dsh >> 1;
    end
  end

endmodule

/* rtl/core/oef_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oef_lane
// One axis of the filter: jump distance term, rate estimate with its own
// divider, rate smoothing, adaptive cutoff and position smoothing.
// ----------------------------------------------------------------------------
module oef_lane import oef_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lane_ctl_t          ctl,
  input  logic signed [31:0] raw_in,
  input  logic [23:0]        lim,
  input  logic [31:0]        dt,
  input  logic [16:0]        ad,
  input  logic [15:0]        min_cutoff,
  input  logic [15:0]        speed_gain,
  output lane_stat_t         stat,
  output logic signed [31:0] sp
);

  logic signed [31:0] raw;
  logic signed [31:0] prev;
  logic signed [31:0] srate;
  logic signed [31:0] rate;
  logic signed [31:0] er;
  logic               over;
  logic [47:0]        sq;
  logic [52:0]        n;
  logic               rneg;
  logic [52:0]        rrem;
  logic [63:0]        rdsh;
  logic [32:0]        rq;
  logic [5:0]         rcnt;
  logic               rbusy;
  logic               rge;
  logic signed [49:0] bp;
  logic [47:0]        spd;
  logic [23:0]        cutoff;
  logic [55:0]        x;
  logic               abusy;
  logic [16:0]        alpha;

  logic signed [32:0] d_pos;
  logic [32:0]        m_pos;
  logic signed [32:0] d_raw;
  logic [32:0]        m_raw;
  logic signed [31:0] rate_sat;
  logic signed [32:0] bd;
  logic [31:0]        emag;
  logic [47:0]        spd_sh;
  logic [48:0]        csum;

  assign d_pos = {raw[31], raw} - {sp[31], sp};
  assign m_pos = d_pos[32] ? 33'(-d_pos) : d_pos;
  assign d_raw = {raw[31], raw} - {prev[31], prev};
  assign m_raw = d_raw[32] ? 33'(-d_raw) : d_raw;
  assign rge   = {11'b0, rrem} >= rdsh;
  assign emag  = er[31] ? 32'(-er) : er;
  assign spd_sh = spd >> FRAC_BITS;
  assign csum   = {33'b0, min_cutoff} + {1'b0, spd_sh};

  always_comb begin
    if (!rneg) begin
      rate_sat = (rq > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : rq[31:0];
    end else begin
      rate_sat = (rq >= 33'h080000000) ? 32'sh80000000 : 32'(-rq[31:0]);
    end
  end

  always_comb begin
    if (ctl.bpp) begin
      bd = d_pos;
    end else begin
      bd = {rate[31], rate} - {srate[31], srate};
    end
  end

  oef_alpha_div u_adiv (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.astart),
    .x     (x),
    .busy  (abusy),
    .alpha (alpha)
  );

  assign stat.over = over;
  assign stat.sq   = sq;
  assign stat.busy = rbusy | abusy;

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      sp    <= '0;
      prev  <= '0;
      srate <= '0;
    end else if (ctl.prime) begin
      sp    <= raw;
      prev  <= raw;
      srate <= '0;
    end else if (ctl.commit) begin
      sp    <= sp + bp[47:16];
      prev  <= raw;
      srate <= er;
    end
  end

  // rate divider control
  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
      rcnt  <= '0;
    end else if (ctl.dstart) begin
      rbusy <= 1'b1;
      rcnt  <= 6'(RATE_STEPS);
    end else if (rbusy) begin
      rcnt <= rcnt - 6'd1;
      if (rcnt == 6'd1) begin
        rbusy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      raw <= raw_in;
    end
    if (ctl.jdist) begin
      over <= m_pos > {9'b0, lim};
      sq   <= m_pos[23:0] * m_pos[23:0];
    end
    if (ctl.rmul) begin
      n    <= m_raw * US_PER_S;
      rneg <= d_raw[32];
    end
    if (ctl.dstart) begin
      rrem <= n;
      rdsh <= {dt, 32'b0};
      rq   <= '0;
    end else if (rbusy) begin
      if (rge) begin
        rrem <= rrem - rdsh[52:0];
      end
      rq   <= {rq[31:0], rge};
      rdsh <= rdsh >> 1;
    end
    if (ctl.rsat) begin
      rate <= rate_sat;
    end
    if (ctl.brp) begin
      bp <= $signed({1'b0, ad}) * bd;
    end else if (ctl.bpp) begin
      bp <= $signed({1'b0, alpha}) * bd;
    end
    if (ctl.bra) begin
      er <= srate + bp[47:16];
    end
    if (ctl.cmul) begin
      spd <= speed_gain * emag;
    end
    if (ctl.csum) begin
      cutoff <= (csum > CUTOFF_MAX) ? 24'hFFFFFF : csum[23:0];
    end
    if (ctl.xmul) begin
      x <= cutoff * dt;
    end
  end

endmodule

/* rtl/core/one_euro_position_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_euro_position_filter_unit
// Adaptive one-euro smoothing of timestamped 3-axis positions.
//
// Input channel: in_valid / in_stall with sample_time_us and pos_x/y/z.
// Output channel: out_valid / out_stall with out_x/y/z and snapped; one
// result per request.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min cutoff,
// 1 speed gain, 2 derivative cutoff, 3 jump limit); other indexes ignored.
// One axis lane per coordinate works in parallel; the merge stage sums the
// jump distance terms and shares the derivative alpha.
// Sequence: a priming or jump sample goes from S_DIST through S_DECIDE and
// S_PRIME to S_OUT, which loads the output register; a filtered sample
// first waits on the 33-step rate divider and the 17-step alpha divider
// in each lane. One request is in work at a time.
// Reset clears the filter to unprimed and loads default registers; the
// first sample after reset primes the filter and is returned snapped.
// A stalled result stays in the output register; the next request may be
// accepted meanwhile and waits at its end until the register is free.
// ----------------------------------------------------------------------------
module one_euro_position_filter_unit import oef_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           sample_time_us,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_x,
  output logic signed [31:0]    out_y,
  output logic signed [31:0]    out_z,
  output logic                  snapped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t      state;
  state_t      state_next;
  lane_ctl_t   ctl;
  lane_stat_t  stat [AXES];

  logic [15:0] min_cutoff;
  logic [15:0] speed_gain;
  logic [15:0] deriv_cutoff;
  logic [23:0] jump_limit;

  logic        primed;
  logic [31:0] last_time;
  logic [31:0] t_in;
  logic [31:0] dt;
  logic [47:0] limsq;
  logic [55:0] xd;
  logic        snap;
  logic        ad_start;
  logic        ad_busy;
  logic [16:0] ad;

  logic signed [31:0] raw_in [AXES];
  logic signed [31:0] sp [AXES];

  logic        accept;
  logic        out_free;
  logic        over_any;
  logic        busy_any;
  logic [49:0] dist2;
  logic        jump;
  logic [31:0] dt_raw;

  assign raw_in[0] = pos_x;
  assign raw_in[1] = pos_y;
  assign raw_in[2] = pos_z;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;
  assign dt_raw   = t_in - last_time;

  always_comb begin
    over_any = 1'b0;
    busy_any = ad_busy;
    dist2    = '0;
    for (int i = 0; i < AXES; i++) begin
      over_any = over_any | stat[i].over;
      busy_any = busy_any | stat[i].busy;
      dist2    = dist2 + {2'b0, stat[i].sq};
    end
    jump = over_any || (dist2 > {2'b0, limsq});
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    oef_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .raw_in     (raw_in[g]),
      .lim        (jump_limit),
      .dt         (dt),
      .ad         (ad),
      .min_cutoff (min_cutoff),
      .speed_gain (speed_gain),
      .stat       (stat[g]),
      .sp         (sp[g])
    );
  end

  oef_alpha_div u_ddiv (
    .clk   (clk),
    .rst   (rst),
    .start (ad_start),
    .x     (xd),
    .busy  (ad_busy),
    .alpha (ad)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_DIST;
      S_DIST:   state_next = S_DECIDE;
      S_DECIDE: state_next = (!primed || jump) ? S_PRIME : S_RMUL;
      S_RMUL:   state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  if (!busy_any) state_next = S_RSAT;
      S_RSAT:   state_next = S_BRP;
      S_BRP:    state_next = S_BRA;
      S_BRA:    state_next = S_CMUL;
      S_CMUL:   state_next = S_CSUM;
      S_CSUM:   state_next = S_XMUL;
      S_XMUL:   state_next = S_ASTART;
      S_ASTART: state_next = S_AWAIT;
      S_AWAIT:  if (!busy_any) state_next = S_BPP;
      S_BPP:    state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_PRIME:  state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // lane controls
  always_comb begin
    ctl        = '0;
    ad_start   = 1'b0;
    ctl.load   = accept;
    ctl.jdist  = state == S_DIST;
    ctl.prime  = state == S_PRIME;
    ctl.rmul   = state == S_RMUL;
    ctl.dstart = state == S_DSTART;
    ctl.rsat   = state == S_RSAT;
    ctl.brp    = state == S_BRP;
    ctl.bra    = state == S_BRA;
    ctl.cmul   = state == S_CMUL;
    ctl.csum   = state == S_CSUM;
    ctl.xmul   = state == S_XMUL;
    ctl.astart = state == S_ASTART;
    ctl.bpp    = state == S_BPP;
    ctl.commit = state == S_COMMIT;
    ad_start   = state == S_DSTART;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff   <= MIN_CUTOFF_RST;
      speed_gain   <= SPEED_GAIN_RST;
      deriv_cutoff <= DERIV_CUTOFF_RST;
      jump_limit   <= JUMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CUTOFF:   min_cutoff   <= cfg_data[15:0];
        REG_SPEED_GAIN:   speed_gain   <= cfg_data[15:0];
        REG_DERIV_CUTOFF: deriv_cutoff <= cfg_data[15:0];
        REG_JUMP_LIMIT:   jump_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter control state
  always_ff @(posedge clk) begin
    if (rst) begin
      primed    <= 1'b0;
      last_time <= '0;
    end else if (state == S_PRIME) begin
      primed    <= 1'b1;
      last_time <= t_in;
    end else if (state == S_RMUL) begin
      last_time <= t_in;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_in <= sample_time_us;
    end
    if (state == S_DIST) begin
      limsq <= jump_limit * jump_limit;
    end
    if (state == S_DECIDE) begin
      dt   <= (dt_raw < DT_MIN_US) ? DT_DEFAULT_US : dt_raw;
      snap <= !primed || jump;
    end
    if (state == S_RMUL) begin
      xd <= 56'(deriv_cutoff) * 56'(dt);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_x   <= sp[0];
      out_y   <= sp[1];
      out_z   <= sp[2];
      snapped <= snap;
    end
  end

  ap_unprimed_snaps: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && !primed) |=> (state == S_PRIME && snap))
    else $error("unprimed sample not snapped");

  ap_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !busy_any)
    else $error("divider busy while idle");

  ap_primed_holds: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("filter lost primed state");

endmodule

/* tb/oef_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oef_checker
// Watches the request, result and register ports of the one-euro position
// filter, predicts every smoothed position with its own fixed-point copy of
// the filter state and compares each result field by field, oldest first.
// ----------------------------------------------------------------------------
module oef_checker import oef_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [31:0]           sample_time_us,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    pos_z,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic signed [31:0]    out_x,
  input  logic signed [31:0]    out_y,
  input  logic signed [31:0]    out_z,
  input  logic                  snapped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic signed [31:0] pos [AXES];
    logic               snap;
  } filtered_pos_t;

  filtered_pos_t filtered_q [$];

  logic [15:0] min_cut, gain, rate_cut;
  logic [23:0] snap_dist;
  logic        is_primed;
  logic [31:0] prev_t;
  longint      raw_prev [AXES];
  longint      pos_est [AXES];
  longint      rate_est [AXES];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint unsigned alpha_of(longint unsigned cutoff, logic [31:0] dt);
    longint unsigned den;
    longint unsigned comp;
    den  = cutoff * longint'({32'd0, dt}) + longint'(ALPHA_C);
    comp = ((longint'(ALPHA_C) << 16) + den - 1) / den;
    return 65536 - comp;
  endfunction

  function automatic longint blend(longint h, longint x, longint unsigned a);
    longint p;
    p = longint'(a) * (x - h);
    if (p >= 0) return h + (p >>> 16);
    return h - ((-p + 65535) >>> 16);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic prime_filter(logic [31:0] t, longint raw [AXES]);
    is_primed = 1'b1;
    prev_t    = t;
    for (int i = 0; i < AXES; i++) begin
      raw_prev[i] = raw[i];
      pos_est[i]  = raw[i];
      rate_est[i] = 0;
    end
  endtask

  task automatic filter_request(output filtered_pos_t res);
    longint raw [AXES];
    longint unsigned lim, dist2, mag, cutoff, a_rate;
    longint d, rate;
    logic [31:0] dt;
    logic jump;
    raw[0] = pos_x;
    raw[1] = pos_y;
    raw[2] = pos_z;
    res.snap = 1'b0;
    if (!is_primed) begin
      prime_filter(sample_time_us, raw);
      res.snap = 1'b1;
    end else begin
      lim   = snap_dist;
      dist2 = 0;
      jump  = 1'b0;
      for (int i = 0; i < AXES; i++) begin
        d   = raw[i] - pos_est[i];
        mag = (d < 0) ? -d : d;
        if (mag > lim) jump = 1'b1;
        else dist2 += mag * mag;
      end
      if (jump || dist2 > lim * lim) begin
        prime_filter(sample_time_us, raw);
        res.snap = 1'b1;
      end else begin
        dt = sample_time_us - prev_t;
        if (dt < DT_MIN_US) dt = DT_DEFAULT_US;
        prev_t = sample_time_us;
        a_rate = alpha_of(rate_cut, dt);
        for (int i = 0; i < AXES; i++) begin
          rate = (raw[i] - raw_prev[i]) * 1000000 / longint'({32'd0, dt});
          if (rate > 64'sd2147483647) rate = 64'sd2147483647;
          if (rate < -64'sd2147483648) rate = -64'sd2147483648;
          rate_est[i] = blend(rate_est[i], rate, a_rate);
          mag    = (rate_est[i] < 0) ? -rate_est[i] : rate_est[i];
          cutoff = min_cut + ((longint'(gain) * mag) >> FRAC_BITS);
          if (cutoff > CUTOFF_MAX) cutoff = CUTOFF_MAX;
          pos_est[i]  = blend(pos_est[i], raw[i], alpha_of(cutoff, dt));
          raw_prev[i] = raw[i];
        end
      end
    end
    for (int i = 0; i < AXES; i++) res.pos[i] = pos_est[i][31:0];
  endtask

  always @(posedge clk) begin
    filtered_pos_t got_exp;
    if (rst) begin
      min_cut   = MIN_CUTOFF_RST;
      gain      = SPEED_GAIN_RST;
      rate_cut  = DERIV_CUTOFF_RST;
      snap_dist = JUMP_LIMIT_RST;
      is_primed = 1'b0;
      prev_t    = '0;
      for (int i = 0; i < AXES; i++) begin
        raw_prev[i] = 0;
        pos_est[i]  = 0;
        rate_est[i] = 0;
      end
      filtered_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_CUTOFF:   min_cut   = cfg_data[15:0];
          REG_SPEED_GAIN:   gain      = cfg_data[15:0];
          REG_DERIV_CUTOFF: rate_cut  = cfg_data[15:0];
          REG_JUMP_LIMIT:   snap_dist = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        filter_request(got_exp);
        filtered_q.insert(filtered_q.size(), got_exp);
      end
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("mismatch: result with no request waiting at %0t", $time);
          fail_count++;
        end else begin
          got_exp = filtered_q[0];
          filtered_q.delete(0);
          if (out_x !== got_exp.pos[0]) report("out_x", out_x, got_exp.pos[0]);
          if (out_y !== got_exp.pos[1]) report("out_y", out_y, got_exp.pos[1]);
          if (out_z !== got_exp.pos[2]) report("out_z", out_z, got_exp.pos[2]);
          if (snapped !== got_exp.snap) report("snapped", snapped, got_exp.snap);
        end
      end
    end
    pending = filtered_q.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the one-euro position filter with directed corner samples and
// random phases of smooth tracks, short and backward timestamps and jumps,
// under several register settings, with bursty requests and a stalling
// receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import oef_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           sample_time_us = '0;
  logic signed [31:0]    pos_x = '0;
  logic signed [31:0]    pos_y = '0;
  logic signed [31:0]    pos_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    out_x, out_y, out_z;
  logic                  snapped;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  logic [31:0] cur_t;
  logic [23:0] cur_lim;
  int          cur_x, cur_y, cur_z;
  int          burst_left;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_cnt = 0;
  int          stall_mode = 0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  one_euro_position_filter_unit dut (.*);

  oef_checker u_checker (.*);

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cnt  <= 400;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 127) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [31:0] t, int x, int y, int z);
    in_valid       <= 1'b1;
    sample_time_us <= t;
    pos_x          <= x;
    pos_y          <= y;
    pos_z          <= z;
    do @(posedge clk); while (in_stall);
    cur_t = t;
    cur_x = x;
    cur_y = y;
    cur_z = z;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] mc, logic [15:0] sg, logic [15:0] dc,
                          logic [23:0] jl);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_MIN_CUTOFF, REG_SPEED_GAIN, REG_DERIV_CUTOFF, REG_JUMP_LIMIT};
    val = '{{8'd0, mc}, {8'd0, sg}, {8'd0, dc}, jl};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    // an unknown index is ignored
    cfg_index <= CFG_IDX_W'($urandom_range(4, 255));
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lim = jl;
  endtask

  task automatic random_request();
    int kind;
    int span;
    logic [31:0] dt;
    kind = $urandom_range(0, 99);
    span = (cur_lim == 0) ? 0 : int'(cur_lim / 2);
    case ($urandom_range(0, 9))
      0:       dt = $urandom_range(0, 99);
      1:       dt = $urandom;
      2:       dt = $urandom_range(100, 300);
      default: dt = $urandom_range(1000, 60000);
    endcase
    if (kind < 82) begin
      send(cur_t + dt, cur_x + $signed($urandom_range(0, 2 * span)) - span,
           cur_y + $signed($urandom_range(0, 2 * span)) - span,
           cur_z + $signed($urandom_range(0, 2 * span)) - span);
    end else if (kind < 92) begin
      send($urandom, $urandom, $urandom, $urandom);
    end else begin
      send(cur_t + dt, cur_x + int'(cur_lim) + $urandom_range(1, 1000), cur_y, cur_z);
    end
  endtask

  initial begin
    burst_left = 0;
    cur_lim = JUMP_LIMIT_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: priming, smooth step, short and backward time, jumps
    send(32'd1000, 0, 0, 0);
    send(32'd17667, 1000, -1000, 500);
    send(32'd17700, 2000, -2000, 900);
    send(32'd12000, 2500, -2500, 1000);
    send(32'd30000, 2500 + 3 * 65536, 0, 0);
    send(32'd40000, 2500 + 3 * 65536, 0, 5 * 65536);
    send(32'd50000, 131072 + 2500 + 3 * 65536, 0, 5 * 65536);
    send(32'd60000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send(32'hffffffff, 32'h80000000, 32'h80000000, 32'h80000000);
    send(32'd70, 32'h80000000, 32'h80000000, 32'h80000000);
    drain();
    set_regs(16'hffff, 16'hffff, 16'hffff, 24'hffffff);
    send(32'd0, 0, 0, 0);
    send(32'd100, 32'h00800000, -32'sh00800000, 32'h00400000);
    send(32'd200, 0, 0, 32'h00ffffff);
    send(32'd300, 0, 32'h00ffffff, 32'h00ffffff);
    drain();
    set_regs(16'd0, 16'd0, 16'd0, 24'd0);
    send(32'd5000, 7, 7, 7);
    send(32'd9000, 7, 7, 7);
    send(32'd9500, 8, 7, 7);
    drain();

    // random phases under several register settings
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_regs(MIN_CUTOFF_RST, SPEED_GAIN_RST, DERIV_CUTOFF_RST, JUMP_LIMIT_RST);
        1: set_regs(16'hffff, 16'hffff, 16'hffff, 24'hffffff);
        2: set_regs(16'd0, 16'd0, 16'd0, 24'd1000);
        default: set_regs(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
      endcase
      for (int n = 0; n < 100; n++) begin
        if (n == 30 && phase % 2 == 0) hold_reqs++;
        if (n == 70) drain();
        random_request();
      end
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
